>>> rtl/okl_pkg.sv
// Shared types, constants and coefficient tables for the sRGB to OKLab converter.
package okl_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int LAB_SHIFT   = 48 - FRAC_BITS;
    localparam int CBRT_STEPS  = 21;
    localparam int PIPE_DEPTH  = 3 + CBRT_STEPS + 2;

    typedef logic [30:0] lin_t;
    typedef lin_t        lin_table_t [256];
    typedef logic [27:0] lms_coef_t;
    typedef lms_coef_t   lms_row_t [3];
    typedef logic [30:0] lms_t;
    typedef logic [20:0] root_t;
    typedef logic signed [31:0] lab_coef_t;

    localparam longint POLY_COEF [10] = '{
        64'sd128616720873440, -64'sd545348320728372, 64'sd944695457285987,
        -64'sd852509147074822, 64'sd417419723518890, -64'sd98309340178371,
        64'sd2207597081864, 64'sd4327343895455, -64'sd176388944706,
        64'sd78165359869
    };

    // Decimal coefficient with ten fraction digits to Q28, rounded to nearest.
    function automatic longint q28c(input longint n);
        return (n * 64'sd268435456 + 64'sd5000000000) / 64'sd10000000000;
    endfunction

    function automatic longint mul_div255(input longint y, input int code);
        longint p;
        p = y * longint'(code);
        if (p >= 0)
            return (p + 127) / 255;
        return -((-p + 127) / 255);
    endfunction

    // Linear value in Q30 for every 8-bit code.
    function automatic lin_table_t build_lin_table();
        lin_table_t tab;
        longint     y;
        for (int c = 0; c < 256; c++)
        begin
            y = POLY_COEF[0];
            for (int i = 1; i < 10; i++)
                y = mul_div255(y, c) + POLY_COEF[i];
            y = mul_div255(y, c);
            if (y < 0)
                y = 0;
            if (y > 64'sd1000000000000)
                y = 64'sd1000000000000;
            tab[c] = 31'((y * 64'sd262144 + 64'sd122070312) / 64'sd244140625);
        end
        return tab;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

    localparam lms_coef_t LMS_COEF [3][3] = '{
        '{28'(q28c(64'sd4122214708)), 28'(q28c(64'sd5363325363)),
          28'(q28c(64'sd514459929))},
        '{28'(q28c(64'sd2119034982)), 28'(q28c(64'sd6806995451)),
          28'(q28c(64'sd1073969566))},
        '{28'(q28c(64'sd883024619)),  28'(q28c(64'sd2817188376)),
          28'(q28c(64'sd6299787005))}
    };

    localparam lab_coef_t LAB_COEF [3][3] = '{
        '{32'(q28c(64'sd2104542553)), 32'(q28c(64'sd7936177850)),
          32'(-q28c(64'sd40720468))},
        '{32'(q28c(64'sd19779984951)), 32'(-q28c(64'sd24285922050)),
          32'(q28c(64'sd4505937099))},
        '{32'(q28c(64'sd259040371)), 32'(q28c(64'sd7827717662)),
          32'(-q28c(64'sd8086757660))}
    };

endpackage

>>> rtl/srgb_to_oklab_converter.sv
// Top level of the sRGB to OKLab pixel converter.
// The converter takes one sRGB pixel with 8-bit channels per word and returns its
// OKLab coordinates, one result word per pixel, in order. It accepts a new pixel
// every cycle while the output word is not held. Its stages are one for the
// linearization table, two for the linear-to-LMS matrix row in each lane,
// 21 for the bit-serial cube root (one result bit per stage), and two for the
// Lab matrix with rounding and saturation. All stages advance together: when
// the output word is held by the consumer, the whole pipeline holds and
// s_axis_tready drops, and it rises again the cycle the word is taken.
// L is unsigned with 16 fraction bits, saturated to 0..1.0; a and b are two's
// complement with 16 fraction bits, saturated to the 16-bit range.
module srgb_to_oklab_converter
    import okl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata   // lightness[16:0], green_red[32:17],
                                       // blue_yellow[48:33], zero[55:49]
);

    logic        en;
    logic        valid_reg [PIPE_DEPTH];
    lin_t        lin_reg   [3];
    root_t       root      [3];
    logic [16:0] lightness;
    logic [15:0] green_red;
    logic [15:0] blue_yellow;

    // Advance whenever the output slot is empty or being taken.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = valid_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // Linearize each channel through the shared constant table.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lin_reg[0] <= LIN_TABLE[s_axis_tdata[7:0]];
            lin_reg[1] <= LIN_TABLE[s_axis_tdata[15:8]];
            lin_reg[2] <= LIN_TABLE[s_axis_tdata[23:16]];
        end
    end

    // One lane per LMS component.
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        okl_lane u_lane
        (
            .clk  (clk),
            .en   (en),
            .lin  (lin_reg),
            .coef (LMS_COEF[i]),
            .root (root[i])
        );
    end

    okl_merge u_merge
    (
        .clk         (clk),
        .en          (en),
        .root        (root),
        .lightness   (lightness),
        .green_red   (green_red),
        .blue_yellow (blue_yellow)
    );

    assign m_axis_tdata = {7'd0, blue_yellow, green_red, lightness};

    // Lightness never leaves its saturated range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> lightness <= 17'd65536)
        else $error("lightness out of range");

    // Table output stays within 1.0 for every code.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> lin_reg[0] <= (31'd1 << 30) && lin_reg[1] <= (31'd1 << 30)
                         && lin_reg[2] <= (31'd1 << 30))
        else $error("linear value above 1.0");

    // An accepted word enters the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> valid_reg[0])
        else $error("accepted word lost at pipeline entry");

endmodule

>>> rtl/okl_cbrt.sv
// Pipelined bit-serial cube root: one result bit per stage, no multipliers.
module okl_cbrt
    import okl_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  lms_t  radicand,
    output root_t root
);

    logic [60:0] rem_reg [CBRT_STEPS];
    root_t       r_reg   [CBRT_STEPS];
    logic [41:0] r2_reg  [CBRT_STEPS];

    for (genvar k = 0; k < CBRT_STEPS; k++)
    begin : g_step
        localparam int B = CBRT_STEPS - 1 - k;

        logic [60:0] rem_in;
        root_t       r_in;
        logic [41:0] r2_in;
        logic [63:0] delta;
        logic [60:0] rem_next;
        root_t       r_next;
        logic [41:0] r2_next;

        if (k == 0)
        begin : g_first
            assign rem_in = {radicand, 30'd0};
            assign r_in   = '0;
            assign r2_in  = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign r_in   = r_reg[k-1];
            assign r2_in  = r2_reg[k-1];
        end

        // (r + 2^B)^3 - r^3 = 3 r^2 2^B + 3 r 2^2B + 2^3B
        always_comb
        begin
            delta = ({22'd0, r2_in} << B) + ({22'd0, r2_in} << (B + 1))
                  + ({43'd0, r_in} << (2 * B)) + ({43'd0, r_in} << (2 * B + 1))
                  + (64'd1 << (3 * B));
            if ({3'd0, rem_in} >= delta)
            begin
                rem_next = rem_in - delta[60:0];
                r_next   = r_in | (21'd1 << B);
                r2_next  = r2_in + ({21'd0, r_in} << (B + 1)) + (42'd1 << (2 * B));
            end
            else
            begin
                rem_next = rem_in;
                r_next   = r_in;
                r2_next  = r2_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                r_reg[k]   <= r_next;
                r2_reg[k]  <= r2_next;
            end
        end
    end

    assign root = r_reg[CBRT_STEPS-1];

endmodule

>>> rtl/okl_lane.sv
// One LMS lane: matrix row, rounding and clamp, then cube root.
module okl_lane
    import okl_pkg::*;
(
    input  logic     clk,
    input  logic     en,
    input  lin_t     lin  [3],
    input  lms_row_t coef,
    output root_t    root
);

    logic [58:0] prod_reg [3];
    lms_t        lms_reg;
    logic [60:0] acc;
    logic [32:0] rounded;
    lms_t        lms_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < 3; j++)
                prod_reg[j] <= {28'd0, lin[j]} * {31'd0, coef[j]};
            lms_reg <= lms_next;
        end
    end

    // Round Q58 to Q30 half up, clamp to 1.0.
    always_comb
    begin
        acc     = {2'd0, prod_reg[0]} + {2'd0, prod_reg[1]} + {2'd0, prod_reg[2]}
                + (61'd1 << 27);
        rounded = acc[60:28];
        if (rounded > (33'd1 << 30))
            lms_next = 31'd1 << 30;
        else
            lms_next = rounded[30:0];
    end

    okl_cbrt u_cbrt
    (
        .clk      (clk),
        .en       (en),
        .radicand (lms_reg),
        .root     (root)
    );

endmodule

>>> rtl/okl_merge.sv
// Merge stage: LMS' to Lab matrix over the three lane roots, round and saturate.
module okl_merge
    import okl_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  root_t        root [3],
    output logic [16:0]  lightness,
    output logic [15:0]  green_red,
    output logic [15:0]  blue_yellow
);

    logic signed [53:0] prod_reg [3][3];
    logic [16:0]        lightness_reg;
    logic [15:0]        green_red_reg;
    logic [15:0]        blue_yellow_reg;
    logic signed [55:0] acc     [3];
    logic signed [55:0] shifted [3];
    logic [16:0]        lightness_next;
    logic [15:0]        green_red_next;
    logic [15:0]        blue_yellow_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= 54'(LAB_COEF[i][j])
                                    * 54'($signed({1'b0, root[j]}));
            lightness_reg   <= lightness_next;
            green_red_reg   <= green_red_next;
            blue_yellow_reg <= blue_yellow_next;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = 56'(prod_reg[i][0]) + 56'(prod_reg[i][1]) + 56'(prod_reg[i][2])
                   + (56'sd1 <<< (LAB_SHIFT - 1));
            shifted[i] = acc[i] >>> LAB_SHIFT;
        end

        if (shifted[0] < 0)
            lightness_next = '0;
        else if (shifted[0] > 56'sd65536)
            lightness_next = 17'd65536;
        else
            lightness_next = shifted[0][16:0];

        if (shifted[1] < -56'sd32768)
            green_red_next = 16'h8000;
        else if (shifted[1] > 56'sd32767)
            green_red_next = 16'h7fff;
        else
            green_red_next = shifted[1][15:0];

        if (shifted[2] < -56'sd32768)
            blue_yellow_next = 16'h8000;
        else if (shifted[2] > 56'sd32767)
            blue_yellow_next = 16'h7fff;
        else
            blue_yellow_next = shifted[2][15:0];
    end

    assign lightness   = lightness_reg;
    assign green_red   = green_red_reg;
    assign blue_yellow = blue_yellow_reg;

endmodule

>>> verif/tb.sv
// Self-checking testbench for the sRGB to OKLab pixel converter.
module tb;
    import okl_pkg::*;

    localparam int          LATENCY     = 26;
    localparam int          RANDOM_PIX  = 1850;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // Pending stimulus entry: a pixel, or a marker that holds the sender
    // until every expected Lab word has come back.
    typedef struct packed {
        logic   drain;
        pixel_t pix;
    } stim_t;

    typedef struct packed {
        logic        [16:0] lightness;
        logic signed [15:0] green_red;
        logic signed [15:0] blue_yellow;
    } lab_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;

    stim_t       pixel_queue[$];
    lab_word_t   lab_expected[$];
    int          error_count;
    int unsigned cycle_count = 0;

    // Predictor tables: linear values in Q30 and both matrices in Q28.
    longint      lin_q30 [256];
    longint      rgb_to_lms [3][3];
    longint      lms_to_lab [3][3];

    srgb_to_oklab_converter u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Ten-digit decimal to Q28, round to nearest.
    function automatic longint dec_to_q28(input longint n);
        return (n * 64'sd268435456 + 64'sd5000000000) / 64'sd10000000000;
    endfunction

    // y * code / 255, rounding half away from zero.
    function automatic longint scale_code(input longint y, input longint code);
        longint p;
        p = y * code;
        if (p >= 0)
            return (p + 127) / 255;
        return -((-p + 127) / 255);
    endfunction

    function automatic longint code_to_linear(input int code);
        longint coef [10];
        longint y;
        coef = '{64'sd128616720873440, -64'sd545348320728372, 64'sd944695457285987,
                 -64'sd852509147074822, 64'sd417419723518890, -64'sd98309340178371,
                 64'sd2207597081864, 64'sd4327343895455, -64'sd176388944706,
                 64'sd78165359869};
        y = coef[0];
        for (int i = 1; i < 10; i++)
            y = scale_code(y, code) + coef[i];
        y = scale_code(y, code);
        // clamp polynomial overshoot to [0, 1]
        if (y < 0)
            y = 0;
        if (y > 64'sd1000000000000)
            y = 64'sd1000000000000;
        return (y * 64'sd262144 + 64'sd122070312) / 64'sd244140625;
    endfunction

    // Floor of the cube root, one result bit per step from the top.
    function automatic longint cube_root(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] cand;
        r = '0;
        for (int b = 20; b >= 0; b--)
        begin
            cand = r | (64'd1 << b);
            if (cand * cand * cand <= n)
                r = cand;
        end
        return longint'(r);
    endfunction

    function automatic lab_word_t predict_lab(input pixel_t pix);
        longint    lin [3];
        longint    root [3];
        longint    acc;
        longint    lab [3];
        lab_word_t w;
        lin[0] = lin_q30[pix.red];
        lin[1] = lin_q30[pix.green];
        lin[2] = lin_q30[pix.blue];
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += lin[j] * rgb_to_lms[i][j];
            acc = (acc + (64'sd1 << 27)) >>> 28;
            if (acc > (64'sd1 << 30))
                acc = 64'sd1 << 30;
            root[i] = cube_root(64'(acc) << 30);
        end
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc += lms_to_lab[i][j] * root[j];
            // round half toward +infinity
            lab[i] = (acc + (64'sd1 << (LAB_SHIFT - 1))) >>> LAB_SHIFT;
        end
        w.lightness   = 17'(lab[0] < 0 ? 0 : (lab[0] > 65536 ? 65536 : lab[0]));
        w.green_red   = 16'(lab[1] < -32768 ? -32768 : (lab[1] > 32767 ? 32767 : lab[1]));
        w.blue_yellow = 16'(lab[2] < -32768 ? -32768 : (lab[2] > 32767 ? 32767 : lab[2]));
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("mismatch %0s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    endtask

    task automatic add_pixel(input int r, input int g, input int b);
        stim_t s;
        s.drain = 1'b0;
        s.pix   = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
        pixel_queue.push_back(s);
    endtask

    // Driver: bursts of random length with random gaps in between, holding at each drain marker.
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left    <= 0;
            gap_left      <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end
            else if (pixel_queue.size() == 0)
                s_axis_tvalid <= 1'b0;
            else if (pixel_queue[0].drain)
            begin
                // hold until the pipeline has returned every result
                s_axis_tvalid <= 1'b0;
                if (!s_axis_tvalid && lab_expected.size() == 0)
                    void'(pixel_queue.pop_front());
            end
            else
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {pixel_queue[0].pix.blue, pixel_queue[0].pix.green,
                                  pixel_queue[0].pix.red};
                void'(pixel_queue.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Monitor: record accepted pixels, check returned words, stall on its own pattern.
    logic [15:0] stall_pattern;
    int          stall_phase;
    always @(posedge clk or negedge rst_n)
    begin
        lab_word_t got;
        lab_word_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_pattern <= 16'hb5c3;
            stall_phase   <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                lab_expected.push_back(predict_lab(pixel_t'({s_axis_tdata[7:0],
                    s_axis_tdata[15:8], s_axis_tdata[23:16]})));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.lightness   = m_axis_tdata[16:0];
                got.green_red   = m_axis_tdata[32:17];
                got.blue_yellow = m_axis_tdata[48:33];
                if (lab_expected.size() == 0)
                begin
                    error_count++;
                    $display("unexpected word %h at cycle %0d", m_axis_tdata, cycle_count);
                end
                else
                begin
                    want = lab_expected.pop_front();
                    if (got.lightness !== want.lightness)
                        report_mismatch("lightness", got.lightness, want.lightness);
                    if (got.green_red !== want.green_red)
                        report_mismatch("green_red", got.green_red, want.green_red);
                    if (got.blue_yellow !== want.blue_yellow)
                        report_mismatch("blue_yellow", got.blue_yellow, want.blue_yellow);
                    if (m_axis_tdata[55:49] !== '0)
                        report_mismatch("pad bits", m_axis_tdata[55:49], 0);
                end
            end
            // advance the stall pattern; bit 9 of the phase counter switches between
            // always ready and patterned stalls
            stall_pattern <= {stall_pattern[14:0], stall_pattern[15] ^ stall_pattern[13]
                              ^ stall_pattern[12] ^ stall_pattern[10]};
            stall_phase   <= stall_phase + 1;
            if (stall_phase[9])
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= stall_pattern[0] | stall_pattern[3];
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("srgb_to_oklab_converter verification failed");
            $finish;
        end
    end

    initial
    begin
        stim_t marker;
        int    sel;
        error_count = 0;
        for (int c = 0; c < 256; c++)
            lin_q30[c] = code_to_linear(c);
        rgb_to_lms = '{'{dec_to_q28(64'sd4122214708), dec_to_q28(64'sd5363325363),
                         dec_to_q28(64'sd514459929)},
                       '{dec_to_q28(64'sd2119034982), dec_to_q28(64'sd6806995451),
                         dec_to_q28(64'sd1073969566)},
                       '{dec_to_q28(64'sd883024619), dec_to_q28(64'sd2817188376),
                         dec_to_q28(64'sd6299787005)}};
        lms_to_lab = '{'{dec_to_q28(64'sd2104542553), dec_to_q28(64'sd7936177850),
                         -dec_to_q28(64'sd40720468)},
                       '{dec_to_q28(64'sd19779984951), -dec_to_q28(64'sd24285922050),
                         dec_to_q28(64'sd4505937099)},
                       '{dec_to_q28(64'sd259040371), dec_to_q28(64'sd7827717662),
                         -dec_to_q28(64'sd8086757660)}};
        marker = '0;
        marker.drain = 1'b1;

        // Directed: black, white, primaries, secondaries, near-white codes
        // where the polynomial overshoots, low codes, alternating bits.
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 255, 0);
        add_pixel(0, 255, 255);
        add_pixel(255, 0, 255);
        add_pixel(254, 254, 254);
        add_pixel(253, 252, 251);
        add_pixel(1, 1, 1);
        add_pixel(2, 3, 4);
        add_pixel(128, 128, 128);
        add_pixel(170, 85, 170);
        add_pixel(85, 170, 85);
        add_pixel(1, 0, 255);
        add_pixel(255, 1, 0);
        add_pixel(0, 1, 254);
        pixel_queue.push_back(marker);

        for (int n = 0; n < RANDOM_PIX; n++)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                add_pixel($urandom_range(0, 255) & 8'hf0 | ($urandom_range(0, 1) ? 8'h0f : 0),
                          $urandom_range(250, 255), $urandom_range(0, 5));
            else if (sel == 1)
            begin
                // random grey level
                int v;
                v = $urandom_range(0, 255);
                add_pixel(v, v, v);
            end
            else
                add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            if (n == RANDOM_PIX / 2)
                pixel_queue.push_back(marker);
        end

        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || s_axis_tvalid || lab_expected.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("srgb_to_oklab_converter verification clean");
        else
            $display("srgb_to_oklab_converter verification failed");
        $finish;
    end

endmodule
